// ----- hw/rtl/tagged_handle_table_assert.svh -----
// ----------------------------------------------------------------------------
// tagged_handle_table_assert.svh
// Assertion macros shared by the handle table RTL.
// ----------------------------------------------------------------------------
`ifndef TAGGED_HANDLE_TABLE_ASSERT_SVH
`define TAGGED_HANDLE_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define THT_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define THT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/tht_pkg.sv -----
// ----------------------------------------------------------------------------
// tht_pkg
// Types and constants shared by the tagged handle table modules.
// ----------------------------------------------------------------------------
package tht_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 112;

   localparam int Q_DEPTH = 2;
   localparam int QPW     = $clog2(Q_DEPTH);

   localparam logic [6:0] REMOVED_MAX = 7'h7F;

   localparam logic [1:0] STATUS_SUCCESS  = 2'd0;
   localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
   localparam logic [1:0] STATUS_FULL     = 2'd2;

   typedef enum logic [1:0] {
      OP_ADD        = 2'd0,
      OP_GET        = 2'd1,
      OP_REMOVE     = 2'd2,
      OP_REMOVE_ALL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_RESULT
   } eng_state_type;

   // Classified request as it sits in the queue.
   typedef struct packed {
      op_type      op;
      logic [15:0] owner;
      logic [31:0] key;
      logic [31:0] idx;      // low half of the handle
      logic [31:0] htag;     // high half of the handle
      logic [31:0] new_tag;  // random tag with zero mapped to one
   } req_entry_type;

   // Result item, status in the lowest bits.
   typedef struct packed {
      logic [6:0]  removed;
      logic [31:0] found;
      logic [63:0] new_handle;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ----- hw/rtl/tht_front.sv -----
// ----------------------------------------------------------------------------
// tht_front
// Request intake: unpacks the transaction, decodes the command and prepares
// index, handle tag and new tag for the engine.
// ----------------------------------------------------------------------------
module tht_front (
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tht_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          q_full,
   input  logic                          eng_clearing,
   output logic                          q_push,
   output tht_pkg::req_entry_type        q_entry
);
   import tht_pkg::*;

   logic [31:0] rnd;

   assign rnd = req_tdata[145:114];

   // Nothing enters while the table memory is being swept after reset.
   assign req_tready = !q_full && !eng_clearing;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      q_entry.op      = op_type'(req_tdata[1:0]);
      q_entry.owner   = req_tdata[17:2];
      q_entry.key     = req_tdata[49:18];
      q_entry.idx     = req_tdata[81:50];
      q_entry.htag    = req_tdata[113:82];
      q_entry.new_tag = (rnd == 32'd0) ? 32'd1 : rnd;
   end

endmodule

// ----- hw/rtl/tht_queue.sv -----
// ----------------------------------------------------------------------------
// tht_queue
// Short request queue between intake and engine.
// ----------------------------------------------------------------------------
module tht_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_push,
   input  tht_pkg::req_entry_type q_wr_entry,
   input  logic                   q_pop,
   output logic                   q_valid,
   output logic                   q_full,
   output tht_pkg::req_entry_type q_rd_entry
);
   import tht_pkg::*;

   req_entry_type  entries [Q_DEPTH];
   logic [QPW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPW:0]   count_ff, count_in;

   assign q_valid    = (count_ff != '0);
   assign q_full     = (count_ff == (QPW+1)'(Q_DEPTH));
   assign q_rd_entry = entries[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPW+1)'(q_push) - (QPW+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         entries[wr_ptr_ff] <= q_wr_entry;
      end
   end

endmodule

// ----- hw/rtl/tht_engine.sv -----
// ----------------------------------------------------------------------------
// tht_engine
// Slot memory and command sequencer: sweep after reset, slot scans for add
// and owner removal, single slot check for get and remove, result register.
// ----------------------------------------------------------------------------
module tht_engine #(
   parameter int CAPACITY = tht_pkg::CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  tht_pkg::req_entry_type         q_entry,
   output logic                           q_pop,
   output logic                           eng_clearing,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tht_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tht_pkg::*;

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic        valid;
      logic [15:0] owner;
      logic [31:0] key;
      logic [31:0] tag;
   } slot_type;

   slot_type      mem [CAPACITY];
   slot_type      rd_q_ff;
   logic          mem_we;
   logic [IW-1:0] mem_wa;
   logic [IW-1:0] mem_ra;
   slot_type      mem_wd;

   eng_state_type state_ff, state_in;
   req_entry_type ent_ff, ent_in;
   logic [CW-1:0] use_cnt_ff, use_cnt_in;
   logic [CW-1:0] scan_ff, scan_in;     // scan address, also the sweep address
   logic          pend_ff, pend_in;     // read data belongs to chk_ff
   logic [IW-1:0] chk_ff, chk_in;
   logic [CW-1:0] last_ff, last_in;     // one past the last surviving slot
   logic [6:0]    rmv_ff, rmv_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          out_free;
   logic          issue;
   logic          hit;
   slot_type      new_slot;

   assign eng_clearing = (state_ff == ST_CLEAR);
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {(RSP_DATA_W - $bits(rsp_type))'(0), rsp_ff};
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign issue        = (scan_ff < use_cnt_ff);
   assign hit          = rd_q_ff.valid && (rd_q_ff.tag == ent_ff.htag) &&
                         (rd_q_ff.owner == ent_ff.owner);

   always_comb begin
      new_slot.valid = 1'b1;
      new_slot.owner = ent_ff.owner;
      new_slot.key   = ent_ff.key;
      new_slot.tag   = ent_ff.new_tag;
   end

   always_comb begin
      state_in     = state_ff;
      ent_in       = ent_ff;
      use_cnt_in   = use_cnt_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      chk_in       = chk_ff;
      last_in      = last_ff;
      rmv_in       = rmv_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mem_we       = 1'b0;
      mem_wa       = chk_ff;
      mem_wd       = '0;
      mem_ra       = scan_ff[IW-1:0];
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = scan_ff[IW-1:0];
            if (scan_ff == CW'(CAPACITY - 1)) begin
               scan_in  = '0;
               state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            mem_ra = q_entry.idx[IW-1:0];
            if (q_valid) begin
               q_pop   = 1'b1;
               ent_in  = q_entry;
               scan_in = '0;
               last_in = '0;
               rmv_in  = '0;
               res_in  = '0;
               case (q_entry.op)
                  OP_GET, OP_REMOVE: begin
                     if (q_entry.idx < 32'(use_cnt_ff)) begin
                        state_in = ST_CHECK;
                     end else begin
                        res_in.status = STATUS_NO_MATCH;
                        state_in      = ST_RESULT;
                     end
                  end
                  default: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end

         ST_CHECK: begin
            state_in = ST_RESULT;
            if (!hit) begin
               res_in.status = STATUS_NO_MATCH;
            end else if (ent_ff.op == OP_GET) begin
               res_in.found = rd_q_ff.key;
            end else begin
               mem_we         = 1'b1;
               mem_wa         = ent_ff.idx[IW-1:0];
               res_in.removed = 7'd1;
            end
         end

         ST_SCAN: begin
            if (issue) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
               chk_in  = scan_ff[IW-1:0];
            end
            if (pend_ff) begin
               if (ent_ff.op == OP_ADD) begin
                  // first free slot below the use count
                  if (!rd_q_ff.valid) begin
                     mem_we            = 1'b1;
                     mem_wa            = chk_ff;
                     mem_wd            = new_slot;
                     res_in.new_handle = {ent_ff.new_tag, 32'(chk_ff)};
                     pend_in           = 1'b0;
                     state_in          = ST_RESULT;
                  end
               end else if (rd_q_ff.valid) begin
                  if (rd_q_ff.owner == ent_ff.owner) begin
                     mem_we = 1'b1;
                     mem_wa = chk_ff;
                     if (rmv_ff != REMOVED_MAX) begin
                        rmv_in = rmv_ff + 1'b1;
                     end
                  end else begin
                     last_in = CW'(chk_ff) + 1'b1;
                  end
               end
            end else if (!issue) begin
               state_in = ST_RESULT;
               if (ent_ff.op == OP_ADD) begin
                  if (use_cnt_ff == CW'(CAPACITY)) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     mem_we            = 1'b1;
                     mem_wa            = use_cnt_ff[IW-1:0];
                     mem_wd            = new_slot;
                     use_cnt_in        = use_cnt_ff + 1'b1;
                     res_in.new_handle = {ent_ff.new_tag, 32'(use_cnt_ff)};
                  end
               end else begin
                  use_cnt_in     = last_ff;
                  res_in.removed = rmv_ff;
               end
            end
         end

         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         use_cnt_ff   <= '0;
         scan_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         use_cnt_ff   <= use_cnt_in;
         scan_ff      <= scan_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      chk_ff  <= chk_in;
      last_ff <= last_in;
      rmv_ff  <= rmv_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_q_ff <= mem[mem_ra];
   end

endmodule

// ----- hw/rtl/tagged_handle_table.sv -----
// ----------------------------------------------------------------------------
// tagged_handle_table
// Fixed-capacity table of tagged key handles with owner checking.
// ----------------------------------------------------------------------------
// Each request transaction carries one command (add, get, remove one handle,
// remove all of an owner) and produces exactly one response transaction.
// After reset the block sweeps its slot memory, one slot a cycle, and
// req_tready stays low during that sweep. A get or a remove steps through
// the engine states idle (slot read), check and result, skipping the check
// when the index is at or past the use count. An add or a remove-by-owner
// scans the slots below the use count one per cycle through the single read
// port of the slot memory; an add stops at the first free slot. A two-entry
// queue sits between the intake and the engine, and the response sits in its
// own register, so requests are still taken while a response waits. Handles
// are tag in bits 63..32 and slot index in bits 31..0; a zero random tag is
// stored and returned as one.
// ----------------------------------------------------------------------------
`include "tagged_handle_table_assert.svh"

module tagged_handle_table #(
   parameter int CAPACITY = tht_pkg::CAPACITY_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request transaction
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] command, [17:2] owner_id, [49:18] key_ref, [113:50] handle,
   // [145:114] random_tag, [151:146] zero
   input  logic [tht_pkg::REQ_DATA_W-1:0] req_tdata,
   // response transaction
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [1:0] status, [65:2] new_handle, [97:66] found_key_ref,
   // [104:98] removed_count, [111:105] zero
   output logic [tht_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import tht_pkg::*;

   logic          q_push;
   logic          q_pop;
   logic          q_valid;
   logic          q_full;
   logic          eng_clearing;
   req_entry_type q_wr_entry;
   req_entry_type q_rd_entry;

   // intake: decode and classify the request
   tht_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .q_full       (q_full),
      .eng_clearing (eng_clearing),
      .q_push       (q_push),
      .q_entry      (q_wr_entry)
   );

   // decouples intake from the engine
   tht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .q_push     (q_push),
      .q_wr_entry (q_wr_entry),
      .q_pop      (q_pop),
      .q_valid    (q_valid),
      .q_full     (q_full),
      .q_rd_entry (q_rd_entry)
   );

   // slot memory, scans and the response register
   tht_engine #(
      .CAPACITY (CAPACITY)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_rd_entry),
      .q_pop        (q_pop),
      .eng_clearing (eng_clearing),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   // no request may slip in while the memory sweep is running
   `THT_ASSERT_IMPLY(a_no_req_in_sweep, clock, reset, req_tvalid && req_tready, !eng_clearing, "request taken during memory sweep")
   // no response can exist before the sweep has finished
   `THT_ASSERT_IMPLY(a_no_rsp_in_sweep, clock, reset, eng_clearing, !rsp_tvalid, "response valid during memory sweep")
   // the engine only pops a non-empty queue
   `THT_ASSERT_IMPLY(a_pop_nonempty, clock, reset, q_pop, q_valid, "pop from empty request queue")
   // an accepted request is waiting in the queue on the next cycle
   `THT_ASSERT_NEXT(a_push_lands, clock, reset, req_tvalid && req_tready, q_valid, "accepted request missing from queue")

endmodule
